// ----- rtl/cdq_pkg.sv -----
// shared types and constants for the circular double-ended queue
`timescale 1ns / 1ps
package cdq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_LEFT  = 2'd0,
		KIND_PUSH_RIGHT = 2'd1,
		KIND_POP_LEFT   = 2'd2,
		KIND_POP_RIGHT  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	typedef struct packed {
		logic take_req;
		logic take_read;
	} dp_cmd_t;

	typedef struct packed {
		logic needs_read;
	} dp_status_t;

endpackage

// ----- rtl/cdq_ifs.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface cdq_req_if import cdq_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [WORD_W-1:0] popped_value;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0] occupancy;
	logic is_empty;

	modport source (output valid, output popped_value, output status, output occupancy,
		output is_empty, input ready);
	modport sink (input valid, input popped_value, input status, input occupancy,
		input is_empty, output ready);
endinterface

// ----- rtl/cdq_ram.sv -----
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
module cdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/cdq_ctrl.sv -----
// controller: request acceptance, read wait and response valid
`timescale 1ns / 1ps
module cdq_ctrl import cdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  dp_status_t dp_status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   rsp_valid_d;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept = req_ready && req_valid;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.take_req = accept;
		cmd.take_read = 1'b0;
		state_d = state_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rsp_valid_d = !dp_status.needs_read;
					if (dp_status.needs_read) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.take_read = 1'b1;
				rsp_valid_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
				rsp_valid_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

// ----- rtl/cdq_datapath.sv -----
// datapath: pointers, count, entry store and response register
`timescale 1ns / 1ps
module cdq_datapath import cdq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 dp_status,
	input  logic [KIND_W-1:0]          kind,
	input  logic signed [WORD_W-1:0]   value,
	output logic signed [WORD_W-1:0]   popped_value,
	output logic [STATUS_W-1:0]        status,
	output logic [OCC_W-1:0]           occupancy,
	output logic                       is_empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [PW-1:0] left_q, left_d;
	logic [PW-1:0] right_q, right_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW+OCC_W-1:0] count_ext;

	logic signed [WORD_W-1:0] popped_value_q;
	status_t status_q, status_d;
	logic [OCC_W-1:0] occupancy_q;
	logic is_empty_q;

	kind_t kind_dec;
	logic is_push, q_empty, q_full, push_ok, pop_ok;
	logic we, re;
	logic [PW-1:0] waddr, raddr;
	logic [WORD_W-1:0] rdata;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
		return (p == '0) ? LAST : p - 1'b1;
	endfunction

	assign kind_dec = kind_t'(kind);
	assign is_push = (kind_dec == KIND_PUSH_LEFT) || (kind_dec == KIND_PUSH_RIGHT);
	assign q_empty = (count_q == '0);
	assign q_full = (count_q == FULL_COUNT);
	assign push_ok = is_push && !q_full;
	assign pop_ok = !is_push && !q_empty;
	assign dp_status.needs_read = pop_ok;

	always_comb begin
		left_d = left_q;
		right_d = right_q;
		count_d = count_q;
		status_d = STATUS_OK;
		waddr = '0;
		raddr = right_q;
		case (kind_dec)
			KIND_PUSH_LEFT, KIND_PUSH_RIGHT: begin
				if (q_full) begin
					status_d = STATUS_FULL;
				end else begin
					count_d = count_q + 1'b1;
					if (q_empty) begin
						left_d = '0;
						right_d = '0;
						waddr = '0;
					end else if (kind_dec == KIND_PUSH_LEFT) begin
						left_d = wrap_dec(left_q);
						waddr = left_d;
					end else begin
						right_d = wrap_inc(right_q);
						waddr = right_d;
					end
				end
			end
			KIND_POP_LEFT, KIND_POP_RIGHT: begin
				raddr = (kind_dec == KIND_POP_LEFT) ? left_q : right_q;
				if (q_empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
					if (count_q == CW'(1)) begin
						left_d = '0;
						right_d = '0;
					end else if (kind_dec == KIND_POP_LEFT) begin
						left_d = wrap_inc(left_q);
					end else begin
						right_d = wrap_dec(right_q);
					end
				end
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
	end

	assign we = cmd.take_req && push_ok;
	assign re = cmd.take_req && pop_ok;
	assign count_ext = {{OCC_W{1'b0}}, count_d};

	cdq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			right_q <= '0;
			count_q <= '0;
		end else if (cmd.take_req) begin
			left_q <= left_d;
			right_q <= right_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			popped_value_q <= '0;
			status_q <= status_d;
			occupancy_q <= count_ext[OCC_W-1:0];
			is_empty_q <= (count_d == '0);
		end else if (cmd.take_read) begin
			popped_value_q <= rdata;
		end
	end

	assign popped_value = popped_value_q;
	assign status = status_q;
	assign occupancy = occupancy_q;
	assign is_empty = is_empty_q;

endmodule

// ----- rtl/circular_double_ended_queue.sv -----
// top level of the circular double-ended queue
// a push or rejected request gives its response in the cycle after the transaction
// a successful pop gives its response via the registered ram read, then the read state
// throughput: one transaction per cycle for pushes and rejected requests unless rsp stalls
// a successful pop blocks the next request until its read state is done
// reset clears pointers, count and response valid; store contents are not cleared
`timescale 1ns / 1ps
module circular_double_ended_queue import cdq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	cdq_req_if.sink   req,
	cdq_rsp_if.source rsp
);

	dp_cmd_t    cmd;
	dp_status_t dp_status;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.dp_status(dp_status),
		.cmd      (cmd)
	);

	cdq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.dp_status   (dp_status),
		.kind        (req.kind),
		.value       (req.value),
		.popped_value(rsp.popped_value),
		.status      (rsp.status),
		.occupancy   (rsp.occupancy),
		.is_empty    (rsp.is_empty)
	);

endmodule

// ----- bench/tb_circular_double_ended_queue.sv -----
// self-checking testbench for the circular double-ended queue
`timescale 1ns / 1ps
module tb_circular_double_ended_queue;
	import cdq_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned RANDOM_ITEMS = 1900;
	localparam int unsigned CALM_ITEMS = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [WORD_W-1:0] popped;
		status_t status;
		logic [OCC_W-1:0] occupancy;
		logic is_empty;
	} deque_result_t;

	class deque_scoreboard;
		logic [WORD_W-1:0] slots [DEPTH];
		int unsigned left_idx;
		int unsigned right_idx;
		int unsigned held;
		deque_result_t awaited [$];

		function new();
			left_idx = 0;
			right_idx = 0;
			held = 0;
		endfunction

		function void note_request(kind_t k, logic [WORD_W-1:0] word);
			deque_result_t r;
			r.popped = '0;
			r.status = STATUS_OK;
			if (k == KIND_PUSH_LEFT || k == KIND_PUSH_RIGHT) begin
				if (held >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					if (held == 0) begin
						left_idx = 0;
						right_idx = 0;
						slots[0] = word;
					end else if (k == KIND_PUSH_LEFT) begin
						left_idx = (left_idx == 0) ? DEPTH - 1 : left_idx - 1;
						slots[left_idx] = word;
					end else begin
						right_idx = (right_idx == DEPTH - 1) ? 0 : right_idx + 1;
						slots[right_idx] = word;
					end
					held++;
				end
			end else if (held == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.popped = (k == KIND_POP_LEFT) ? slots[left_idx] : slots[right_idx];
				if (held == 1) begin
					left_idx = 0;
					right_idx = 0;
				end else if (k == KIND_POP_LEFT) begin
					left_idx = (left_idx == DEPTH - 1) ? 0 : left_idx + 1;
				end else begin
					right_idx = (right_idx == 0) ? DEPTH - 1 : right_idx - 1;
				end
				held--;
			end
			r.occupancy = OCC_W'(held);
			r.is_empty = (held == 0);
			awaited.push_back(r);
		endfunction

		function string check_response(logic [WORD_W-1:0] popped, logic [STATUS_W-1:0] status,
				logic [OCC_W-1:0] occupancy, logic is_empty);
			deque_result_t r;
			string msg;
			msg = "";
			if (awaited.size() == 0) begin
				return "response with no request outstanding";
			end
			r = awaited.pop_front();
			if (popped !== r.popped)
				msg = {msg, $sformatf(" popped_value got %h want %h", popped, r.popped)};
			if (status !== r.status)
				msg = {msg, $sformatf(" status got %0d want %0d", status, r.status)};
			if (occupancy !== r.occupancy)
				msg = {msg, $sformatf(" occupancy got %0d want %0d", occupancy, r.occupancy)};
			if (is_empty !== r.is_empty)
				msg = {msg, $sformatf(" is_empty got %b want %b", is_empty, r.is_empty)};
			return msg;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit quiet;
	int unsigned errors;
	int unsigned idle_cycles;
	deque_scoreboard sb = new();

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	circular_double_ended_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t:%s", $realtime, msg);
		errors++;
	endtask

	task automatic send_request(input kind_t k, input logic [WORD_W-1:0] word);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.value <= word;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// response sink with random stall bursts
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// monitor of both channels
	always @(posedge clk) begin
		string msg;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				msg = sb.check_response(rsp_ch.popped_value, rsp_ch.status, rsp_ch.occupancy,
					rsp_ch.is_empty);
				if (msg != "")
					report_mismatch(msg);
				moved = 1'b1;
			end
			if (req_ch.valid && req_ch.ready) begin
				sb.note_request(kind_t'(req_ch.kind), req_ch.value);
				moved = 1'b1;
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned push_pct;
		kind_t k;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_PUSH_LEFT;
		req_ch.value <= '0;
		arst_n <= 1'b0;
		quiet = 1'b0;
		errors = 0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops from empty, single-entry push and pop at both ends
		send_request(KIND_POP_LEFT, 32'hffff_ffff);
		send_request(KIND_POP_RIGHT, 32'h0000_0000);
		send_request(KIND_PUSH_RIGHT, 32'h7fff_ffff);
		send_request(KIND_POP_RIGHT, 32'h0000_0000);
		send_request(KIND_PUSH_LEFT, 32'h8000_0000);
		send_request(KIND_POP_LEFT, 32'hffff_ffff);
		// fill to full from both sides, wrapping the left pointer
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 4)
				0: send_request(KIND_PUSH_LEFT, 32'h5555_5555 ^ i);
				1: send_request(KIND_PUSH_RIGHT, 32'haaaa_aaaa ^ i);
				2: send_request(KIND_PUSH_LEFT, 32'hffff_ffff ^ i);
				default: send_request(KIND_PUSH_RIGHT, 32'h0000_0000 | i);
			endcase
		end
		send_request(KIND_PUSH_LEFT, 32'h1234_5678);
		send_request(KIND_PUSH_RIGHT, 32'h8765_4321);
		send_request(KIND_POP_LEFT, 32'h0);
		send_request(KIND_POP_RIGHT, 32'h0);

		push_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - CALM_ITEMS)
				quiet = 1'b1;
			// biased phases sweep the occupancy between empty and full
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			if ($urandom_range(0, 99) < push_pct)
				k = $urandom_range(0, 1) ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT;
			else
				k = $urandom_range(0, 1) ? KIND_POP_RIGHT : KIND_POP_LEFT;
			send_request(k, pick_word());
		end
		req_ch.valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
